[rtl/core/eci_pkg.sv]
package eci_pkg;

   // Input progress is unsigned Q1.16 with one integer bit.
   localparam int PROG_FRAC_BITS = 16;
   localparam int PROG_W         = PROG_FRAC_BITS + 1;
   localparam logic [PROG_W-1:0] PROG_ONE  = PROG_W'(1) << PROG_FRAC_BITS;
   localparam logic [PROG_W-1:0] PROG_HALF = PROG_W'(1) << (PROG_FRAC_BITS - 1);

   // Cell counts of the three chains.
   localparam int ITERS     = 16;
   localparam int DIV_STEPS = 32;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [31:0] LOG2E_Q30   = 32'sd1549082005;
   localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;
   localparam logic [31:0]        ANG_QUARTER = 32'h4000_0000;
   localparam logic [31:0]        ANG_HALF    = 32'h8000_0000;

   // atan(2^-i) in Q0.32 turns.
   localparam logic [31:0] ATAN_TURNS [ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   // Register indexes of the control port.
   localparam logic [2:0] REG_START_VALUE = 3'd0;
   localparam logic [2:0] REG_END_VALUE   = 3'd1;
   localparam logic [2:0] REG_CURVE_MODE  = 3'd2;
   localparam logic [2:0] REG_FREQUENCY   = 3'd3;
   localparam logic [2:0] REG_PHASE_TURNS = 3'd4;
   localparam logic [2:0] REG_STEEPNESS   = 3'd5;

   typedef enum logic [1:0] {
      MODE_CONSTANT = 2'd0,
      MODE_LINEAR   = 2'd1,
      MODE_SINE     = 2'd2,
      MODE_LOGISTIC = 2'd3
   } curve_mode_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [32:0] z;
   } cordic_state_type;

   typedef struct packed {
      logic [30:0] m;
      logic [ITERS-1:0] f;
   } exp_state_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] dvs;
      logic [31:0] dsr;
      logic [31:0] quo;
   } div_state_type;

   typedef struct packed {
      logic [31:0]       mant;
      logic signed [8:0] expo;
   } mant_exp_type;

   // 2^(2^-j) in Q2.30: repeated floored square root starting from 2.0.
   function automatic logic [31:0] eci_root(input int j);
      longint unsigned v;
      longint unsigned r;
      longint unsigned bit_v;
      longint unsigned rt;
      rt = 64'd1 << 31;
      for (int s = 1; s <= j; s++) begin
         v     = rt << 30;
         r     = 0;
         bit_v = 64'd1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (v >= r + bit_v) begin
               v = v - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
         rt = r;
      end
      return rt[31:0];
   endfunction

endpackage

[rtl/core/eci_cordic_cell.sv]
module eci_cordic_cell import eci_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [3:0]       shift_i,
   input  logic [31:0]      atan_i,
   input  cordic_state_type st_i,
   output cordic_state_type st_o
);

   cordic_state_type   st_ff;
   cordic_state_type   st_in;
   logic signed [33:0] xs;
   logic signed [33:0] ys;
   logic signed [32:0] at;

   always_comb begin
      xs = st_i.x >>> shift_i;
      ys = st_i.y >>> shift_i;
      at = $signed({1'b0, atan_i});
      // rotate toward zero residual angle
      if (!st_i.z[32]) begin
         st_in.x = st_i.x - ys;
         st_in.y = st_i.y + xs;
         st_in.z = st_i.z - at;
      end else begin
         st_in.x = st_i.x + ys;
         st_in.y = st_i.y - xs;
         st_in.z = st_i.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

[rtl/core/eci_exp_cell.sv]
module eci_exp_cell import eci_pkg::*; (
   input  logic          clock,
   input  logic          adv,
   input  logic [30:0]   root_i,
   input  exp_state_type st_i,
   output exp_state_type st_o
);

   exp_state_type st_ff;
   exp_state_type st_in;
   logic [61:0]   prod;

   always_comb begin
      prod     = {31'b0, st_i.m} * {31'b0, root_i};
      // fold in this fraction bit's root, then advance the fraction
      st_in.m  = st_i.f[ITERS-1] ? prod[60:30] : st_i.m;
      st_in.f  = {st_i.f[ITERS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

[rtl/core/eci_div_cell.sv]
module eci_div_cell import eci_pkg::*; (
   input  logic          clock,
   input  logic          adv,
   input  div_state_type st_i,
   output div_state_type st_o
);

   div_state_type st_ff;
   div_state_type st_in;
   logic [32:0]   trial;
   logic [32:0]   diff;

   always_comb begin
      trial     = {st_i.rem, st_i.dsr[31]};
      diff      = trial - {1'b0, st_i.dvs};
      st_in.dvs = st_i.dvs;
      st_in.dsr = {st_i.dsr[30:0], 1'b0};
      // restoring step: keep the difference when the divisor fits
      if (trial >= {1'b0, st_i.dvs}) begin
         st_in.rem = diff[31:0];
         st_in.quo = {st_i.quo[30:0], 1'b1};
      end else begin
         st_in.rem = trial[31:0];
         st_in.quo = {st_i.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign st_o = st_ff;

endmodule

[rtl/core/easing_curve_interpolator.sv]
// Throughput: one transaction per cycle unless the output stalls; the longest path has
// 57 register stages (front end, 16 exp cells, 32 divider cells, blend); every mode
// flows through it.
// Reset: synchronous, active high; clears all valid bits and loads the registers with
// their default values (start 0, end 1.0, linear mode, frequency 1.0, phase 0, w 10.0).
module easing_curve_interpolator import eci_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [16:0] progress
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] curve_value
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   // Stage map (S0 is loaded at accept):
   //   S0  clamped progress
   //   S1  sine angle, exp arguments
   //   S2  exp arguments scaled by log2(e); CORDIC cells fill S2..S17
   //   S3..S18  exp cells, S18 clamped sine
   //   S19 mantissa/exponent of 1 + e^x, divider setup
   //   S20..S51 divider cells
   //   S52 select q and shift, S53 partial products, S54 product, S55 delta
   //   then the output register.
   localparam int NSTAGE = 56;
   localparam int T_LEN  = 52;
   localparam int QS_LEN = 34;
   localparam int R_LEN  = 33;
   localparam int K_LEN  = 16;

   localparam logic [34:0] DELTA_CAP   = 35'h4_0000_0000;
   localparam logic [63:0] DELTA_CAP64 = 64'h4_0000_0000;

   // ---------------- control registers ----------------
   logic signed [31:0] start_ff;
   logic signed [31:0] end_ff;
   curve_mode_type     mode_ff;
   logic [15:0]        freq_ff;
   logic [15:0]        phase_ff;
   logic signed [15:0] steep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 32'sd0;
         end_ff   <= 32'sd65536;
         mode_ff  <= MODE_LINEAR;
         freq_ff  <= 16'd256;
         phase_ff <= 16'd0;
         steep_ff <= 16'sd2560;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_START_VALUE: start_ff <= csr_wdata;
            REG_END_VALUE:   end_ff   <= csr_wdata;
            REG_CURVE_MODE:  mode_ff  <= curve_mode_type'(csr_wdata[1:0]);
            REG_FREQUENCY:   freq_ff  <= csr_wdata[15:0];
            REG_PHASE_TURNS: phase_ff <= csr_wdata[15:0];
            REG_STEEPNESS:   steep_ff <= csr_wdata[15:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // ---------------- flow control ----------------
   // The whole pipe advances together. It stalls only when the last stage holds a
   // result and the output register is full and not being taken; a bubble in the
   // last stage lets the pipe keep accepting behind a waiting result.
   logic              vld_ff [NSTAGE];
   logic              rsp_tvalid_ff;
   logic signed [31:0] curve_ff;
   logic              adv;
   logic              out_load;

   assign adv        = !vld_ff[NSTAGE-1] || !rsp_tvalid_ff || rsp_tready;
   assign out_load   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = curve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTAGE; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff[0] <= req_tvalid;
            for (int k = 1; k < NSTAGE; k++) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (out_load) begin
            rsp_tvalid_ff <= vld_ff[NSTAGE-1];
         end
      end
   end

   // ---------------- S0: clamp progress ----------------
   logic [PROG_W-1:0] t_clamp;
   logic [PROG_W-1:0] t_ff [T_LEN];

   // progress above one saturates to one
   assign t_clamp = (req_tdata[PROG_W-1:0] > PROG_ONE) ? PROG_ONE : req_tdata[PROG_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0] <= t_clamp;
         for (int k = 1; k < T_LEN; k++) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
   end

   // ---------------- S1: sine angle and exp arguments ----------------
   logic [32:0]        ft_prod;
   logic [31:0]        ang;
   logic [31:0]        ang_rel;
   logic [31:0]        zu;
   logic signed [17:0] half_m_t;
   logic signed [33:0] pd;
   logic signed [31:0] xn_c;
   logic signed [32:0] z1_ff;
   logic signed [31:0] xn1_ff;
   logic signed [31:0] xd1_ff;

   always_comb begin
      // angle in Q0.32 turns, taken modulo one turn
      ft_prod  = {17'b0, freq_ff} * {16'b0, t_ff[0]};
      ang      = {ft_prod[23:0], 8'b0} + {phase_ff, 16'b0};
      // fold the left half plane onto the right: sin(1/2 - a) = sin(a)
      ang_rel  = ang - ANG_QUARTER;
      zu       = ang_rel[31] ? ang : (ANG_HALF - ang);
      // logistic arguments in Q8.24: -w/2 and w*(1/2 - t)
      half_m_t = $signed({1'b0, PROG_HALF}) - $signed({1'b0, t_ff[0]});
      pd       = steep_ff * half_m_t;
      xn_c     = -$signed({steep_ff[15], steep_ff, 15'b0});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z1_ff  <= $signed({zu[31], zu});
         xn1_ff <= xn_c;
         xd1_ff <= pd[31:0];
      end
   end

   // ---------------- S2: scale by log2(e) ----------------
   logic signed [63:0] pn;
   logic signed [63:0] pdl;
   logic signed [38:0] yn2_ff;
   logic signed [38:0] yd2_ff;

   assign pn  = xn1_ff * LOG2E_Q30;
   assign pdl = xd1_ff * LOG2E_Q30;

   always_ff @(posedge clock) begin
      if (adv) begin
         yn2_ff <= pn[62:24];
         yd2_ff <= pdl[62:24];
      end
   end

   // ---------------- CORDIC chain: S2..S17 ----------------
   cordic_state_type cor_st [ITERS+1];

   assign cor_st[0] = '{x: CORDIC_GAIN, y: 34'sd0, z: z1_ff};

   for (genvar c = 0; c < ITERS; c++) begin : g_cordic
      eci_cordic_cell u_cell (
         .clock   (clock),
         .adv     (adv),
         .shift_i (4'(c)),
         .atan_i  (ATAN_TURNS[c]),
         .st_i    (cor_st[c]),
         .st_o    (cor_st[c+1])
      );
   end

   // ---------------- S18: clamped sine as Q1.31 progress ----------------
   logic signed [33:0] y_clamp;
   logic signed [33:0] q_sine;
   logic [31:0]        qs_ff [QS_LEN];

   always_comb begin
      y_clamp = cor_st[ITERS].y;
      if (y_clamp > $signed({2'b0, ONE_Q30})) begin
         y_clamp = $signed({2'b0, ONE_Q30});
      end else if (y_clamp < -$signed({2'b0, ONE_Q30})) begin
         y_clamp = -$signed({2'b0, ONE_Q30});
      end
      q_sine = y_clamp + $signed({2'b0, ONE_Q30});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qs_ff[0] <= q_sine[31:0];
         for (int k = 1; k < QS_LEN; k++) begin
            qs_ff[k] <= qs_ff[k-1];
         end
      end
   end

   // ---------------- exp chains: S3..S18 ----------------
   // Split y into integer power k and fraction f; cells apply 2^f bit by bit.
   exp_state_type     expn_st [ITERS+1];
   exp_state_type     expd_st [ITERS+1];
   logic signed [8:0] kn_ff [K_LEN];
   logic signed [8:0] kd_ff [K_LEN];

   assign expn_st[0] = '{m: ONE_Q30[30:0], f: yn2_ff[29:30-ITERS]};
   assign expd_st[0] = '{m: ONE_Q30[30:0], f: yd2_ff[29:30-ITERS]};

   always_ff @(posedge clock) begin
      if (adv) begin
         kn_ff[0] <= yn2_ff[38:30];
         kd_ff[0] <= yd2_ff[38:30];
         for (int k = 1; k < K_LEN; k++) begin
            kn_ff[k] <= kn_ff[k-1];
            kd_ff[k] <= kd_ff[k-1];
         end
      end
   end

   for (genvar c = 0; c < ITERS; c++) begin : g_exp
      localparam logic [31:0] ROOT_C = eci_root(c + 1);
      eci_exp_cell u_num (
         .clock  (clock),
         .adv    (adv),
         .root_i (ROOT_C[30:0]),
         .st_i   (expn_st[c]),
         .st_o   (expn_st[c+1])
      );
      eci_exp_cell u_den (
         .clock  (clock),
         .adv    (adv),
         .root_i (ROOT_C[30:0]),
         .st_i   (expd_st[c]),
         .st_o   (expd_st[c+1])
      );
   end

   // ---------------- S19: 1 + e^x as mantissa and exponent ----------------
   function automatic mant_exp_type form_mant(input logic [30:0] m, input logic signed [8:0] k);
      mant_exp_type res;
      logic [8:0]   nk;
      logic [31:0]  add;
      nk  = -k;
      add = '0;
      if (!k[8]) begin
         // large power: the added one becomes 2^-k at this scale
         if (k <= 9'sd30) begin
            add = ONE_Q30 >> k[4:0];
         end
         res.mant = {1'b0, m} + add;
         res.expo = k - 9'sd30;
      end else begin
         // negative power: shrink e^x against the one
         res.mant = ONE_Q30 + ({1'b0, m} >> nk);
         res.expo = -9'sd30;
      end
      return res;
   endfunction

   mant_exp_type      mn;
   mant_exp_type      md;
   div_state_type     dv19_ff;
   logic signed [8:0] r_ff [R_LEN];

   assign mn = form_mant(expn_st[ITERS].m, kn_ff[K_LEN-1]);
   assign md = form_mant(expd_st[ITERS].m, kd_ff[K_LEN-1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         // dividend is mn * 2^30; the first 30 bits preload the remainder
         dv19_ff.rem <= {2'b0, mn.mant[31:2]};
         dv19_ff.dvs <= md.mant;
         dv19_ff.dsr <= {mn.mant[1:0], 30'b0};
         dv19_ff.quo <= '0;
         r_ff[0]     <= mn.expo - md.expo - 9'sd30;
         for (int k = 1; k < R_LEN; k++) begin
            r_ff[k] <= r_ff[k-1];
         end
      end
   end

   // ---------------- divider chain: S20..S51 ----------------
   div_state_type div_st [DIV_STEPS+1];

   assign div_st[0] = dv19_ff;

   for (genvar c = 0; c < DIV_STEPS; c++) begin : g_div
      eci_div_cell u_cell (
         .clock (clock),
         .adv   (adv),
         .st_i  (div_st[c]),
         .st_o  (div_st[c+1])
      );
   end

   // ---------------- S52: pick scale q * 2^r for the active mode ----------------
   logic signed [32:0] diff;
   logic signed [32:0] diff_neg;
   logic [31:0]        q_c;
   logic signed [8:0]  r_c;
   logic [31:0]        q52_ff;
   logic signed [8:0]  r52_ff;
   logic [31:0]        mag52_ff;
   logic               neg52_ff;

   always_comb begin
      diff     = $signed({end_ff[31], end_ff}) - $signed({start_ff[31], start_ff});
      diff_neg = -diff;
      unique case (mode_ff)
         MODE_CONSTANT: begin
            q_c = 32'd1;
            r_c = 9'sd0;
         end
         MODE_LINEAR: begin
            q_c = {{(32-PROG_W){1'b0}}, t_ff[T_LEN-1]};
            r_c = -9'(PROG_FRAC_BITS);
         end
         MODE_SINE: begin
            q_c = qs_ff[QS_LEN-1];
            r_c = -9'sd31;
         end
         MODE_LOGISTIC: begin
            q_c = div_st[DIV_STEPS].quo;
            r_c = r_ff[R_LEN-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q52_ff   <= q_c;
         r52_ff   <= r_c;
         mag52_ff <= diff[32] ? diff_neg[31:0] : diff[31:0];
         neg52_ff <= diff[32];
      end
   end

   // ---------------- S53/S54: |end - start| * q in two halves ----------------
   logic [47:0]       pl53_ff;
   logic [47:0]       ph53_ff;
   logic signed [8:0] r53_ff;
   logic              neg53_ff;
   logic [63:0]       prod54_ff;
   logic signed [8:0] r54_ff;
   logic              neg54_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pl53_ff   <= {16'b0, mag52_ff} * {32'b0, q52_ff[15:0]};
         ph53_ff   <= {16'b0, mag52_ff} * {32'b0, q52_ff[31:16]};
         r53_ff    <= r52_ff;
         neg53_ff  <= neg52_ff;
         prod54_ff <= {16'b0, pl53_ff} + {ph53_ff, 16'b0};
         r54_ff    <= r53_ff;
         neg54_ff  <= neg53_ff;
      end
   end

   // ---------------- S55: shift, round half away, cap at 2^34 ----------------
   logic        big;
   logic [97:0] shl;
   logic [8:0]  nsh;
   logic [63:0] tt;
   logic [63:0] rnd;
   logic [34:0] delta_c;
   logic [34:0] delta55_ff;
   logic        neg55_ff;

   always_comb begin
      big     = 1'b0;
      shl     = {34'b0, prod54_ff} << r54_ff[5:0];
      nsh     = -r54_ff;
      tt      = prod54_ff >> (nsh[6:0] - 7'd1);
      rnd     = {1'b0, tt[63:1]} + {63'b0, tt[0]};
      delta_c = '0;
      if (!r54_ff[8]) begin
         // left shift: anything past the cap pins to the cap
         if (r54_ff > 9'sd34) begin
            big = (prod54_ff != 64'd0);
         end else begin
            big = ((prod54_ff >> (6'd34 - r54_ff[5:0])) != 64'd0);
         end
         delta_c = big ? DELTA_CAP : shl[34:0];
      end else if (nsh <= 9'd64) begin
         delta_c = (rnd > DELTA_CAP64) ? DELTA_CAP : rnd[34:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         delta55_ff <= delta_c;
         neg55_ff   <= neg54_ff;
      end
   end

   // ---------------- output: start +/- delta, saturate ----------------
   logic signed [36:0] s37;
   logic signed [36:0] d37;
   logic signed [36:0] sum;
   logic signed [31:0] curve_in;

   always_comb begin
      s37 = {{5{start_ff[31]}}, start_ff};
      d37 = $signed({2'b0, delta55_ff});
      sum = neg55_ff ? (s37 - d37) : (s37 + d37);
      if (sum > 37'sd2147483647) begin
         curve_in = 32'sh7FFF_FFFF;
      end else if (sum < -37'sd2147483648) begin
         curve_in = 32'sh8000_0000;
      end else begin
         curve_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         curve_ff <= curve_in;
      end
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
   import eci_pkg::*;

   // Run limit in clock cycles; the slowest legal run is far below this.
   localparam int CYCLE_LIMIT = 600000;
   // Pipeline latency of the top level, plus margin.
   localparam int FLUSH_CYCLES = 70;
   localparam int LONG_HOLD = 400;
   localparam logic [2:0] REG_UNUSED = 3'd6;
   localparam longint unsigned Q30_UNIT = 64'd1 << 30;
   localparam longint unsigned DELTA_LIMIT = 64'd1 << 34;
   localparam longint SINE_GAIN = 652032874;
   localparam longint LOG2E_FIX = 1549082005;
   localparam longint ATAN_STEP [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;
   typedef struct {
      row_kind_type kind;
      logic [2:0]   addr;     // register for writes
      logic [31:0]  value;    // register data or progress
      bit           pinned;   // expected value typed in below
      logic [31:0]  curve;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;    // [16:0] progress
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] curve_value
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;

   // Typed-in expectation that travels with the request.
   logic        req_pin = 1'b0;
   logic [31:0] req_pin_curve = '0;

   // Shadow copy of the control registers.
   logic signed [31:0] start_reg = 0;
   logic signed [31:0] end_reg = 65536;
   curve_mode_type     mode_reg = MODE_LINEAR;
   logic [15:0]        freq_reg = 16'd256;
   logic [15:0]        phase_reg = 16'd0;
   logic signed [15:0] steep_reg = 16'sd2560;

   longint unsigned root_q30 [0:16];
   logic [31:0] curve_q [$];
   int fail_count = 0;
   int cycle_count = 0;
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_style = 0;
   int burst_left = 0;

   easing_curve_interpolator u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root = 0;
      longint unsigned probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // 1 + e^x, x in Q8.24, as mant * 2^expo.
   function automatic void exp_plus_one(input longint x, output longint unsigned mant,
                                        output int expo);
      longint y30, k;
      longint unsigned frac, m;
      y30  = (x * LOG2E_FIX) >>> 24;
      k    = y30 >>> 30;
      frac = longint'(y30) & (Q30_UNIT - 1);
      m    = Q30_UNIT;
      for (int j = 1; j <= 16; j++)
         if (frac[30-j]) m = (m * root_q30[j]) >> 30;
      if (k >= 0) begin
         mant = m + ((k <= 30) ? (Q30_UNIT >> k) : 64'd0);
         expo = int'(k) - 30;
      end else begin
         mant = Q30_UNIT + ((-k < 64) ? (m >> (-k)) : 64'd0);
         expo = -30;
      end
   endfunction

   // sin of an angle in Q0.32 turns, Q2.30 result clamped to +-1.
   function automatic longint sine_turns(logic [31:0] ang);
      logic [31:0] folded;
      logic signed [31:0] zs;
      longint x, y, z, nx;
      folded = ((ang - ANG_QUARTER) < ANG_HALF) ? (ANG_HALF - ang) : ang;
      zs = folded;
      z  = zs;
      x  = SINE_GAIN;
      y  = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= ATAN_STEP[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += ATAN_STEP[i];
         end
         x = nx;
      end
      if (y > longint'(Q30_UNIT)) y = Q30_UNIT;
      if (y < -longint'(Q30_UNIT)) y = -longint'(Q30_UNIT);
      return y;
   endfunction

   // start + (end - start) * q * 2^r, rounded half away, saturated.
   function automatic logic [31:0] blend_curve(longint unsigned q, int r);
      longint s, diff, res;
      longint unsigned mag, prod, delta;
      s    = start_reg;
      diff = longint'(end_reg) - s;
      mag  = (diff < 0) ? -diff : diff;
      prod = mag * q;
      if (r >= 0) begin
         if (prod == 0) delta = 0;
         else if (r >= 34 || prod > (DELTA_LIMIT >> r)) delta = DELTA_LIMIT;
         else delta = prod << r;
      end else begin
         delta = (-r > 64) ? 64'd0 : ((prod >> (-r - 1)) + 1) >> 1;
         if (delta > DELTA_LIMIT) delta = DELTA_LIMIT;
      end
      res = (diff < 0) ? s - longint'(delta) : s + longint'(delta);
      if (res > 64'sh7FFFFFFF) res = 64'sh7FFFFFFF;
      if (res < -64'sh80000000) res = -64'sh80000000;
      return res[31:0];
   endfunction

   function automatic logic [31:0] predict_curve(logic [16:0] progress);
      longint unsigned t, ang, mn, md;
      longint w;
      int en, ed;
      t = (progress > PROG_ONE) ? PROG_ONE : progress;
      case (mode_reg)
         MODE_CONSTANT: return blend_curve(1, 0);
         MODE_LINEAR:   return blend_curve(t, -PROG_FRAC_BITS);
         MODE_SINE: begin
            ang = ((longint'(freq_reg) * t) << 8) + (longint'(phase_reg) << 16);
            return blend_curve(sine_turns(ang[31:0]) + longint'(Q30_UNIT), -31);
         end
         default: begin
            w = steep_reg;
            exp_plus_one(-w * 32768, mn, en);
            exp_plus_one(w * (32768 - longint'(t)), md, ed);
            return blend_curve((mn << 30) / md, en - ed - 30);
         end
      endcase
   endfunction

   initial begin
      root_q30[0] = 2 * Q30_UNIT;
      for (int j = 1; j <= 16; j++) root_q30[j] = int_sqrt(root_q30[j-1] << 30);
   end

   // Record expectations on request transactions, check response transactions.
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            curve_q.push_back(req_pin ? req_pin_curve : predict_curve(req_tdata[16:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (curve_q.size() == 0) begin
               $error("unexpected response transaction, curve_value %h", rsp_tdata);
               fail_count++;
            end else begin
               want = curve_q.pop_front();
               if (rsp_tdata !== want) begin
                  $error("curve_value expected %h actual %h", want, rsp_tdata);
                  fail_count++;
               end
            end
         end
      end
   end

   // Response side: a randomly re-picked stall style, plus long holds on request.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (cycle_count % 100 == 0) stall_style = $urandom_range(0, 3);
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((cycle_count % 4) != 0);
         endcase
      end
   end

   // Update the shadow, then drive one register write for the next edge.
   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      case (addr)
         REG_START_VALUE: start_reg = data;
         REG_END_VALUE:   end_reg   = data;
         REG_CURVE_MODE:  mode_reg  = curve_mode_type'(data[1:0]);
         REG_FREQUENCY:   freq_reg  = data[15:0];
         REG_PHASE_TURNS: phase_reg = data[15:0];
         REG_STEEPNESS:   steep_reg = data[15:0];
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Offer one progress value and hold it until accepted; valid stays high.
   task automatic send_progress(logic [16:0] progress, bit pinned, logic [31:0] curve);
      csr_we        <= 1'b0;
      req_tvalid    <= 1'b1;
      req_tdata     <= {7'd0, progress};
      req_pin       <= pinned;
      req_pin_curve <= curve;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected response has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      @(posedge clock);
      while (curve_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [16:0] random_progress;
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 17'd0;
               1: return PROG_ONE;
               2: return PROG_ONE - 1;
               default: return 17'd1;
            endcase
         1: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [31:0] random_q16_16;
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return $urandom;
         default: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      endcase
   endfunction

   stim_row_type directed [] = '{
      // reset defaults: linear from 0 to 1.0
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       1, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd65536,   1, 32'd65536},
      '{ROW_ITEM,  REG_START_VALUE, 32'd32768,   1, 32'd32768},
      '{ROW_ITEM,  REG_START_VALUE, 32'd1,       1, 32'd1},
      '{ROW_ITEM,  REG_START_VALUE, 32'd131071,  1, 32'd65536},   // progress saturates
      // full-scale span
      '{ROW_WRITE, REG_START_VALUE, 32'h8000_0000, 0, 32'd0},
      '{ROW_WRITE, REG_END_VALUE,   32'h7FFF_FFFF, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd65536,   1, 32'h7FFF_FFFF},
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       1, 32'h8000_0000},
      '{ROW_ITEM,  REG_START_VALUE, 32'd40000,   0, 32'd0},
      // constant mode with junk in the upper bits, then a write to an unused index
      '{ROW_WRITE, REG_CURVE_MODE,  32'hFFFF_FFFC, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd12345,   1, 32'h7FFF_FFFF},
      '{ROW_WRITE, REG_UNUSED,      32'h0000_0001, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       1, 32'h7FFF_FFFF},
      // sinusoid
      '{ROW_WRITE, REG_START_VALUE, 32'hFFFF_0000, 0, 32'd0},
      '{ROW_WRITE, REG_END_VALUE,   32'h0001_0000, 0, 32'd0},
      '{ROW_WRITE, REG_CURVE_MODE,  32'h0000_0002, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd16384,   0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd65536,   0, 32'd0},
      '{ROW_WRITE, REG_FREQUENCY,   32'hABCD_FFFF, 0, 32'd0},
      '{ROW_WRITE, REG_PHASE_TURNS, 32'h1234_FFFF, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd40000,   0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd65536,   0, 32'd0},
      // logistic, default width, then both steepness extremes and zero
      '{ROW_WRITE, REG_CURVE_MODE,  32'h0000_0003, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd32768,   0, 32'd0},
      '{ROW_WRITE, REG_STEEPNESS,   32'hFFFF_8000, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd65536,   0, 32'd0},
      '{ROW_WRITE, REG_STEEPNESS,   32'h0000_7FFF, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd0,       0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd65536,   0, 32'd0},
      '{ROW_WRITE, REG_STEEPNESS,   32'h0000_0000, 0, 32'd0},
      '{ROW_ITEM,  REG_START_VALUE, 32'd30000,   0, 32'd0}
   };

   initial begin
      bit busy;
      logic [15:0] freq, steep;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table; drain before any register write.
      busy = 0;
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_WRITE) begin
            if (busy) drain();
            busy = 0;
            write_reg(directed[i].addr, directed[i].value);
         end else begin
            busy = 1;
            send_progress(directed[i].value[16:0], directed[i].pinned, directed[i].curve);
         end
      end
      drain();

      // Random phases: new settings each time, extremes included.
      for (int ph = 0; ph < 8; ph++) begin
         freq  = (ph == 2) ? 16'd0 : (ph == 6) ? 16'hFFFF : 16'($urandom_range(0, 2048));
         steep = (ph == 3) ? 16'h8000 : (ph == 7) ? 16'h7FFF
               : 16'($urandom_range(0, 8192)) - 16'd4096;
         write_reg(REG_START_VALUE, random_q16_16());
         write_reg(REG_END_VALUE, random_q16_16());
         write_reg(REG_CURVE_MODE, {30'($urandom_range(0, 16383)), 2'(ph % 4)});
         write_reg(REG_FREQUENCY, {16'($urandom), freq});
         write_reg(REG_PHASE_TURNS, $urandom);
         write_reg(REG_STEEPNESS, {16'($urandom), steep});
         // Once, hold the response side off long enough to back up the pipeline.
         if (ph == 1) hold_ticket <= hold_ticket + 1;
         burst_left = 0;
         for (int n = 0; n < 100; n++) begin
            if (ph != 1 && burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) begin
                  req_tvalid <= 1'b0;
                  csr_we     <= 1'b0;
                  repeat ($urandom_range(1, 8)) @(posedge clock);
               end
            end
            if (burst_left > 0) burst_left--;
            send_progress(random_progress(), 0, 32'd0);
         end
         drain();
      end

      repeat (FLUSH_CYCLES) @(posedge clock);
      if (fail_count == 0 && curve_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
